FILE: sv/spdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_pkg
// Shared types and fixed constants of the sweep peak direction finder.
// ----------------------------------------------------------------------------
package spdf_pkg;

    // Fixed field widths
    localparam int RANGE_BITS = 12;
    localparam int TOTAL_W    = RANGE_BITS + 2;   // up to three samples
    localparam int ANGLE_W    = 8;
    localparam int FILL_W     = 2;
    localparam int DEC_W      = 2;

    // Stream widths
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;

    // Divide by three: floor(n * 43691 / 2^17) is exact for n below 2^15
    localparam int RECIP3_W     = 16;
    localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;
    localparam int RECIP3_SHIFT = 17;
    localparam int PROD_W       = TOTAL_W + RECIP3_W;

    // Command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Decision codes
    localparam logic [DEC_W-1:0] DEC_NONE    = 2'd0;
    localparam logic [DEC_W-1:0] DEC_REVERSE = 2'd1;
    localparam logic [DEC_W-1:0] DEC_SPIN    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_AVG,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;   // latch the input item
        logic step;      // window, angle and sweep update
        logic divide;    // window average
        logic emit;      // peak update and output load
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a result
    } t_dp_status;

endpackage

FILE: sv/spdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_ctrl
// Sequencer: one item at a time through sum, average and emit steps.
// ----------------------------------------------------------------------------
module spdf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  spdf_pkg::t_dp_status  i_status,
    output spdf_pkg::t_dp_cmd     o_cmd
);
    import spdf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) n_state = ST_SUM;
            end
            ST_SUM:  n_state = ST_AVG;
            ST_AVG:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.divide  = 1'b0;
        o_cmd.emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_tready      = 1'b1;
                o_cmd.capture = s_tvalid;
            end
            ST_SUM:  o_cmd.step   = 1'b1;
            ST_AVG:  o_cmd.divide = 1'b1;
            ST_EMIT: o_cmd.emit   = i_status.out_free;
            default: s_tready     = 1'b0;
        endcase
    end

endmodule

FILE: sv/spdf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_datapath
// Sweep state, window sum, average, peak tracking and output register.
// ----------------------------------------------------------------------------
module spdf_datapath #(
    parameter int WINDOW_SIZE = 3,
    parameter int ANGLE_STEP  = 5,
    parameter int SWEEP_LIMIT = 90
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [spdf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [spdf_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                i_cfg_we,
    input  logic [spdf_pkg::RANGE_BITS-1:0]     i_cfg_wdata,
    input  spdf_pkg::t_dp_cmd                   i_cmd,
    output spdf_pkg::t_dp_status                o_status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spdf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import spdf_pkg::*;

    localparam logic signed [ANGLE_W-1:0] STEP_A  = ANGLE_W'(ANGLE_STEP);
    localparam logic signed [ANGLE_W-1:0] LIMIT_A = ANGLE_W'(SWEEP_LIMIT);
    localparam logic signed [ANGLE_W-1:0] HALF1   = ANGLE_W'((ANGLE_STEP * 1) / 2);
    localparam logic signed [ANGLE_W-1:0] HALF2   = ANGLE_W'((ANGLE_STEP * 2) / 2);
    localparam logic signed [ANGLE_W-1:0] HALF3   = ANGLE_W'((ANGLE_STEP * 3) / 2);
    localparam logic [FILL_W-1:0]         WIN_F   = FILL_W'(WINDOW_SIZE);

    // configuration
    logic [RANGE_BITS-1:0] r_thresh;

    // sweep state
    logic signed [ANGLE_W-1:0] r_angle;
    logic                      r_active;
    logic [TOTAL_W-1:0]        r_total;
    logic [FILL_W-1:0]         r_fill;
    logic [RANGE_BITS-1:0]     r_peak;
    logic signed [ANGLE_W-1:0] r_peak_angle;

    // latched item
    logic                  r_cmd;
    logic                  r_vld;
    logic [RANGE_BITS-1:0] r_val;

    // window under judgement
    logic                      r_judge;
    logic                      r_done;
    logic [TOTAL_W-1:0]        r_jtotal;
    logic [FILL_W-1:0]         r_jfill;
    logic signed [ANGLE_W-1:0] r_jangle;
    logic [RANGE_BITS-1:0]     r_avg;

    // step logic
    logic [FILL_W-1:0]         w_fill_inc;
    logic [TOTAL_W-1:0]        w_total_inc;
    logic signed [ANGLE_W-1:0] w_angle_next;
    logic                      w_end;
    logic                      w_full;
    logic signed [ANGLE_W-1:0] w_half;

    assign w_fill_inc   = r_fill + FILL_W'(1);
    assign w_total_inc  = r_total + TOTAL_W'(r_val);
    assign w_angle_next = r_angle + STEP_A;
    assign w_end        = (w_angle_next > LIMIT_A);
    assign w_full       = (w_fill_inc >= WIN_F);

    always_comb begin
        case (w_fill_inc)
            2'd1:    w_half = HALF1;
            2'd2:    w_half = HALF2;
            2'd3:    w_half = HALF3;
            default: w_half = '0;
        endcase
    end

    // average: one multiply by the reciprocal of three, or a shift
    logic [PROD_W-1:0]     w_prod;
    logic [RANGE_BITS-1:0] w_avg;

    assign w_prod = PROD_W'(r_jtotal) * PROD_W'(RECIP3);

    always_comb begin
        case (r_jfill)
            2'd1:    w_avg = r_jtotal[RANGE_BITS-1:0];
            2'd2:    w_avg = r_jtotal[1 +: RANGE_BITS];
            2'd3:    w_avg = w_prod[RECIP3_SHIFT +: RANGE_BITS];
            default: w_avg = '0;
        endcase
    end

    // emit logic
    logic                      w_take;
    logic [RANGE_BITS-1:0]     w_peak_fin;
    logic signed [ANGLE_W-1:0] w_peak_angle_fin;
    logic [DEC_W-1:0]          w_decision;

    assign w_take           = r_judge && (r_avg > r_peak);
    assign w_peak_fin       = w_take ? r_avg : r_peak;
    assign w_peak_angle_fin = w_take ? r_jangle : r_peak_angle;

    always_comb begin
        if (!r_active && (r_angle > LIMIT_A)) begin
            w_decision = (w_peak_fin < r_thresh) ? DEC_REVERSE : DEC_SPIN;
        end else begin
            w_decision = DEC_NONE;
        end
    end

    assign o_status.out_free = !m_tvalid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // payload latches
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= s_tuser[0];
            r_vld <= s_tuser[1];
            r_val <= s_tdata[RANGE_BITS-1:0];
        end
        if (i_cmd.divide) begin
            r_avg <= w_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle      <= '0;
            r_active     <= 1'b0;
            r_total      <= '0;
            r_fill       <= '0;
            r_peak       <= '0;
            r_peak_angle <= '0;
            r_judge      <= 1'b0;
            r_done       <= 1'b0;
            r_jtotal     <= '0;
            r_jfill      <= '0;
            r_jangle     <= '0;
            m_tvalid     <= 1'b0;
            m_tdata      <= '0;
            m_tlast      <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                if (r_cmd == CMD_START) begin
                    r_angle      <= -LIMIT_A;
                    r_active     <= 1'b1;
                    r_peak       <= '0;
                    r_peak_angle <= '0;
                    r_total      <= '0;
                    r_fill       <= '0;
                    r_judge      <= 1'b0;
                    r_done       <= 1'b0;
                end else if (r_active && r_vld) begin
                    r_jtotal <= w_total_inc;
                    r_jfill  <= w_fill_inc;
                    r_angle  <= w_angle_next;
                    if (w_full) begin
                        // full window: judged at the last sample's angle less half the window span
                        r_judge  <= 1'b1;
                        r_jangle <= r_angle - w_half;
                        r_total  <= '0;
                        r_fill   <= '0;
                    end else if (w_end && (w_fill_inc > FILL_W'(1))) begin
                        // leftover window at sweep end: angle after the step, less half the span
                        r_judge  <= 1'b1;
                        r_jangle <= w_angle_next - w_half;
                        r_total  <= '0;
                        r_fill   <= '0;
                    end else begin
                        r_judge  <= 1'b0;
                        r_total  <= w_total_inc;
                        r_fill   <= w_fill_inc;
                    end
                    r_done <= w_end;
                    if (w_end) begin
                        r_active <= 1'b0;
                    end
                end else begin
                    r_judge <= 1'b0;
                    r_done  <= 1'b0;
                end
            end

            if (i_cmd.emit) begin
                r_peak       <= w_peak_fin;
                r_peak_angle <= w_peak_angle_fin;
                m_tvalid     <= 1'b1;
                m_tlast      <= r_done;
                m_tdata      <= {1'b0, w_decision, w_peak_fin, w_peak_angle_fin,
                                 r_active, r_angle};
            end else if (m_tvalid && m_tready) begin
                m_tvalid     <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/sweep_peak_direction_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sweep_peak_direction_finder
// Finds the clearest direction over one sensor sweep from window averages.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): one transfer per command. tuser[0] is the command
//   (start a sweep, or deliver a sample), tuser[1] the ping-ok flag, and
//   tdata[11:0] the range sample.
//   Output stream (m_*): exactly one result transfer per input transfer,
//   in order. tlast marks the transfer that ended the sweep.
//   Config: i_cfg_we writes the clear threshold from i_cfg_wdata; write it
//   only while no transfer is in flight.
// Sequence
//   Each item runs through accept, window update, average (one multiply by
//   the reciprocal of three, or a shift), peak update with output load. The
//   sequencer holds one item at a time, so s_tready rises again at the edge
//   that loads the result.
// Reset
//   Synchronous, active low. Clears sweep state, peak, threshold and m_tvalid.
// Stall
//   A held result waits in the output register; the next item is worked up
//   to its emit step and then waits until m_tready frees the register.
// ----------------------------------------------------------------------------
module sweep_peak_direction_finder #(
    parameter int WINDOW_SIZE = 3,    // 1 .. 3
    parameter int ANGLE_STEP  = 5,    // 1 .. 30
    parameter int SWEEP_LIMIT = 90    // 10 .. 90
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spdf_pkg::S_TDATA_W-1:0]      s_tdata,  // [11:0] range_value
    input  logic [spdf_pkg::S_TUSER_W-1:0]      s_tuser,  // [0] command, [1] range_valid
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] next_angle, [8] scanning, [16:9] best_angle,
    // [28:17] best_range, [30:29] decision
    output logic [spdf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,  // sweep_done
    // configuration
    input  logic                                i_cfg_we,
    input  logic [spdf_pkg::RANGE_BITS-1:0]     i_cfg_wdata
);
    import spdf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    spdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // sweep state, window average, peak and output register
    spdf_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .ANGLE_STEP  (ANGLE_STEP),
        .SWEEP_LIMIT (SWEEP_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: sv/spdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_checker
// Port-level checks on the sweep peak direction finder.
// ----------------------------------------------------------------------------
module spdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one item in flight: no back-to-back accepts
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // sweep end shows scanning low and a decision
    a_end_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> !m_tdata[8] && (m_tdata[30:29] != 2'd0))
        else $error("sweep end without decision");

    // a decision only while not scanning
    a_dec_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[30:29] != 2'd0) |-> !m_tdata[8])
        else $error("decision during sweep");

endmodule

bind sweep_peak_direction_finder spdf_checker u_spdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sweep peak direction finder.
// ----------------------------------------------------------------------------
// A short directed run first covers:
//   - a sample while idle
//   - a failed ping
//   - the all-ones and all-zeros windows
//   - a tie
//   - a restart mid-sweep
// Whole sweeps with random content follow, in four handshake phases:
//   - free flow
//   - a sender that often idles
//   - a receiver that often stalls
//   - both idling now and then
// A new clear threshold is written before each phase, while no transfer is
// in flight. A last phase holds the receiver off for a long stretch so that
// the block backs up and stalls its input.
// A scoreboard models the block, queues one expected report per accepted
// input transfer, and checks each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import spdf_pkg::*;

    localparam int WINDOW_SIZE       = 3;
    localparam int ANGLE_STEP        = 5;
    localparam int SWEEP_LIMIT       = 90;
    // valid samples from -SWEEP_LIMIT until the angle passes +SWEEP_LIMIT
    localparam int SAMPLES_PER_SWEEP = 2 * SWEEP_LIMIT / ANGLE_STEP + 1;
    localparam int PHASE_ITEMS       = 400;

    // One output transfer as the block should report it
    typedef struct packed {
        logic signed [ANGLE_W-1:0]    next_angle;
        logic                         scanning;
        logic                         sweep_done;
        logic signed [ANGLE_W-1:0]    best_angle;
        logic [RANGE_BITS-1:0]        best_range;
        logic [DEC_W-1:0]             decision;
    } t_report;

    // ------------------------------------------------------------------------
    // Scoreboard: own model of the sweep, plus the queue of expected reports
    // ------------------------------------------------------------------------
    class t_direction_scoreboard;
        t_report                  pending_reports[$];
        logic [RANGE_BITS-1:0]    threshold;
        logic signed [ANGLE_W-1:0] angle;
        logic                     active;
        logic [TOTAL_W-1:0]       total;
        logic [FILL_W-1:0]        fill;
        logic [RANGE_BITS-1:0]    peak_range;
        logic signed [ANGLE_W-1:0] peak_angle;
        int                       errors;

        function new();
            threshold  = '0;
            angle      = '0;
            active     = 1'b0;
            total      = '0;
            fill       = '0;
            peak_range = '0;
            peak_angle = '0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // truncated window average; only a strictly larger one is kept
        function void close_window();
            logic [TOTAL_W-1:0] avg;
            if (fill != 0) begin
                avg = total / fill;
                if (avg > peak_range) begin
                    peak_range = avg[RANGE_BITS-1:0];
                    peak_angle = angle - ANGLE_W'(ANGLE_STEP * int'(fill) / 2);
                end
            end
            fill  = '0;
            total = '0;
        endfunction

        // accepted input transfer: step the model, queue the report
        function void take_item(logic cmd, logic ok, logic [RANGE_BITS-1:0] value);
            t_report rep;
            logic    done;
            done = 1'b0;
            if (cmd == CMD_START) begin
                angle      = ANGLE_W'(-SWEEP_LIMIT);
                active     = 1'b1;
                peak_range = '0;
                peak_angle = '0;
                total      = '0;
                fill       = '0;
            end else if (active && ok) begin
                total = total + TOTAL_W'(value);
                fill  = fill + FILL_W'(1);
                if (fill >= WINDOW_SIZE)
                    close_window();
                angle = angle + ANGLE_W'(ANGLE_STEP);
                if (angle > SWEEP_LIMIT) begin
                    // a lone leftover sample is dropped
                    if (fill > 1)
                        close_window();
                    active = 1'b0;
                    done   = 1'b1;
                end
            end
            rep.next_angle = angle;
            rep.scanning   = active;
            rep.sweep_done = done;
            rep.best_angle = peak_angle;
            rep.best_range = peak_range;
            if (!active && angle > SWEEP_LIMIT)
                rep.decision = (peak_range < threshold) ? DEC_REVERSE : DEC_SPIN;
            else
                rep.decision = DEC_NONE;
            pending_reports.push_back(rep);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t ERROR %s: expected %0d actual %0d",
                         $time, field, want, got);
            end
        endfunction

        // accepted output transfer
        function void check_report(logic [M_TDATA_W-1:0] data, logic last);
            t_report want;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t ERROR unexpected report: expected none actual %h",
                         $time, data);
                return;
            end
            want = pending_reports.pop_front();
            compare("next_angle", int'(want.next_angle), int'($signed(data[7:0])));
            compare("scanning",   int'(want.scanning),   int'(data[8]));
            compare("best_angle", int'(want.best_angle), int'($signed(data[16:9])));
            compare("best_range", int'(want.best_range), int'(data[28:17]));
            compare("decision",   int'(want.decision),   int'(data[30:29]));
            compare("sweep_done", int'(want.sweep_done), int'(last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;   // [11:0] range_value
    logic [S_TUSER_W-1:0]    s_tuser;   // [0] command, [1] range_valid
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // [7:0] next_angle, [8] scanning, [16:9] best_angle,
    // [28:17] best_range, [30:29] decision
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;   // sweep_done
    logic                    i_cfg_we;
    logic [RANGE_BITS-1:0]   i_cfg_wdata;

    t_direction_scoreboard sb = new();

    int src_idle_pct   = 0;   // chance per cycle that the sender idles
    int sink_stall_pct = 0;   // chance per cycle that the receiver stalls
    int sink_hold      = 0;   // cycles of forced receiver hold-off left
    int items_sent     = 0;

    always #5 i_clk = ~i_clk;

    sweep_peak_direction_finder #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .ANGLE_STEP  (ANGLE_STEP),
        .SWEEP_LIMIT (SWEEP_LIMIT)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Receiver: checks each transfer, stalls at random or for a set hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_report(m_tdata, m_tlast);
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // Offer one item; random idle cycles first. Called on a clock edge.
    task automatic send_item(input logic cmd, input logic ok,
                             input logic [RANGE_BITS-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {ok, cmd};
        s_tdata  <= {{(S_TDATA_W-RANGE_BITS){1'b0}}, value};
        do @(posedge i_clk); while (!s_tready);
        sb.take_item(cmd, ok, value);
        items_sent++;
    endtask

    // Stop offering and wait until every expected report is in.
    task automatic await_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        // let the sequencer drop back to idle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_threshold(input logic [RANGE_BITS-1:0] value);
        await_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.threshold = value;
    endtask

    // One well-formed sweep with random content, failed pings, the odd
    // restart, and a few stray samples once it is over.
    task automatic run_sweep();
        int                    mode;
        int                    left;
        logic [RANGE_BITS-1:0] value;
        mode = $urandom_range(3);
        send_item(CMD_START, 1'($urandom_range(1)), RANGE_BITS'($urandom_range(4095)));
        left = SAMPLES_PER_SWEEP;
        while (left > 0) begin
            if ($urandom_range(99) < 1) begin
                send_item(CMD_START, 1'($urandom_range(1)),
                          RANGE_BITS'($urandom_range(4095)));
                left = SAMPLES_PER_SWEEP;
            end else if ($urandom_range(99) < 15) begin
                send_item(CMD_SAMPLE, 1'b0, RANGE_BITS'($urandom_range(4095)));
            end else begin
                case (mode)
                    0: value = RANGE_BITS'($urandom_range(4095));
                    1: value = $urandom_range(1) ? 12'hFFF : 12'h000;
                    2: value = RANGE_BITS'($urandom_range(8, 6));      // plenty of ties
                    default: value = RANGE_BITS'($urandom_range(4095, 3968));
                endcase
                send_item(CMD_SAMPLE, 1'b1, value);
                left--;
            end
        end
        repeat ($urandom_range(3))
            send_item(CMD_SAMPLE, 1'($urandom_range(1)), RANGE_BITS'($urandom_range(4095)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int src_pct_tab[4]  = '{0, 79, 0, 27};
    int sink_pct_tab[4] = '{0, 0, 79, 27};
    int thr_tab[4];
    int phase_start;

    initial begin
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: threshold still at its reset value
        send_item(CMD_SAMPLE, 1'b1, 12'hFFF);       // sample while idle
        send_item(CMD_START,  1'b0, 12'h000);
        send_item(CMD_SAMPLE, 1'b0, 12'hFFF);       // failed ping
        repeat (3) send_item(CMD_SAMPLE, 1'b1, 12'hFFF);
        repeat (3) send_item(CMD_SAMPLE, 1'b1, 12'h000);
        repeat (3) send_item(CMD_SAMPLE, 1'b1, 12'hFFF);  // tie, no update
        send_item(CMD_START,  1'b1, 12'hFFF);       // restart mid-sweep
        send_item(CMD_SAMPLE, 1'b1, 12'd1);
        send_item(CMD_SAMPLE, 1'b1, 12'd2);
        send_item(CMD_SAMPLE, 1'b1, 12'd2);
        send_item(CMD_SAMPLE, 1'b1, 12'hFFE);
        send_item(CMD_SAMPLE, 1'b1, 12'hFFF);
        send_item(CMD_SAMPLE, 1'b1, 12'hFFF);
        send_item(CMD_SAMPLE, 1'b1, 12'h800);
        send_item(CMD_SAMPLE, 1'b0, 12'h000);

        // random sweeps; each phase starts on a fresh threshold, idle state
        thr_tab = '{4095, 0, $urandom_range(4095), 4000};
        for (int p = 0; p < 4; p++) begin
            program_threshold(RANGE_BITS'(thr_tab[p]));
            src_idle_pct   = src_pct_tab[p];
            sink_stall_pct = sink_pct_tab[p];
            // stray samples after the last sweep see the new threshold
            repeat (2)
                send_item(CMD_SAMPLE, 1'($urandom_range(1)),
                          RANGE_BITS'($urandom_range(4095)));
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_sweep();
        end

        // back-pressure: receiver held off while the sender keeps offering
        program_threshold(RANGE_BITS'($urandom_range(4095)));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = 300;
        send_item(CMD_START, 1'b0, 12'h000);
        repeat (29) send_item(CMD_SAMPLE, 1'b1, RANGE_BITS'($urandom_range(4095)));

        await_quiet();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
